/* rtl/kle_pkg.sv */
// Shared types and constants for the keyed LRU entry cache.
// Used by the entry RAM, the scan unit and the top level; depends on nothing.
`default_nettype none
package kle_pkg;

    localparam int SLOTS      = 8;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int FRAME_BITS = 32;
    localparam int MIN_LIMIT  = 2;
    localparam int PADDR_W    = 2;

    localparam logic [2:0] FLAG_REJECTED = 3'b100;
    localparam logic [2:0] FLAG_ACCEPTED = 3'b111;

    typedef enum logic [2:0] {
        MODE_LOOKUP,
        MODE_PEEK,
        MODE_ASSIGN,
        MODE_REC_REJECTED,
        MODE_REC_ACCEPTED,
        MODE_DROP_EPOCH,
        MODE_DROP_RESOURCE,
        MODE_RETIRE
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RENUM,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [63:0]           handle;
        logic [31:0]           size;
        logic [31:0]           fmt;
        logic [63:0]           epochs;
        logic [2:0]            flags;
        logic [31:0]           hits;
        logic [FRAME_BITS-1:0] first;
        logic [FRAME_BITS-1:0] last;
        logic [IDX_W-1:0]      order;
    } t_entry;

    typedef struct packed {
        t_mode                 mode;
        logic [63:0]           handle;
        logic [31:0]           size;
        logic [31:0]           fmt;
        logic [63:0]           epochs;
        logic [FRAME_BITS-1:0] frame;
        logic [31:0]           age;
        logic [2:0]            flags;
        logic [31:0]           hits;
        logic [FRAME_BITS-1:0] first;
    } t_op;

    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  match_idx;
        t_entry            match_ent;
        logic              victim_found;
        logic [IDX_W-1:0]  victim_idx;
        t_entry            victim_ent;
        logic [SLOTS-1:0]  drop_mask;
        logic [SLOTS-1:0]  drop_rank;
    } t_scan_res;

    typedef struct packed {
        logic                  hit;
        logic [2:0]            flags;
        logic [31:0]           hits;
        logic [31:0]           first;
        logic [31:0]           last;
        logic [CNT_W-1:0]      removed;
        logic [CNT_W-1:0]      live;
    } t_result;

endpackage
`default_nettype wire

/* rtl/kle_ram.sv */
// Entry store of the cache: one write port, one read port, registered read data.
// Depends on kle_pkg for the entry type and depth.
`default_nettype none
module kle_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [kle_pkg::IDX_W-1:0] i_waddr,
    input  wire kle_pkg::t_entry          i_wdata,
    input  wire logic [kle_pkg::IDX_W-1:0] i_raddr,
    output kle_pkg::t_entry               o_rdata
);
    import kle_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* rtl/kle_scan.sv */
// Scan unit: looks at one entry per cycle and keeps the key match, the
// eviction victim and the set of entries to drop. Depends on kle_pkg.
`default_nettype none
module kle_scan (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clear,
    input  wire logic                      i_sample,
    input  wire logic [kle_pkg::IDX_W-1:0] i_idx,
    input  wire logic                      i_slot_valid,
    input  wire kle_pkg::t_entry           i_ent,
    input  wire kle_pkg::t_op              i_op,
    output kle_pkg::t_scan_res             o_res
);
    import kle_pkg::*;

    t_scan_res r_res;
    logic      key_eq;
    logic      better;
    logic      drop;

    always_comb begin
        key_eq = i_slot_valid && (i_ent.handle == i_op.handle) &&
                 (i_ent.size == i_op.size) && (i_ent.fmt == i_op.fmt) &&
                 (i_ent.epochs == i_op.epochs);
        better = i_slot_valid && (!r_res.victim_found ||
                 (i_ent.last < r_res.victim_ent.last) ||
                 ((i_ent.last == r_res.victim_ent.last) &&
                  ((i_ent.hits < r_res.victim_ent.hits) ||
                   ((i_ent.hits == r_res.victim_ent.hits) &&
                    (i_ent.order < r_res.victim_ent.order)))));
        case (i_op.mode)
            MODE_DROP_EPOCH:    drop = i_ent.epochs[63:32] != i_op.epochs[63:32];
            MODE_DROP_RESOURCE: drop = i_ent.handle == i_op.handle;
            MODE_RETIRE:        drop = (i_op.frame > i_ent.last) &&
                                       ((i_op.frame - i_ent.last) > i_op.age);
            default:            drop = 1'b0;
        endcase
        drop = drop && i_slot_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_res.match_found  <= 1'b0;
            r_res.victim_found <= 1'b0;
            r_res.drop_mask    <= '0;
            r_res.drop_rank    <= '0;
        end else if (i_sample) begin
            if (key_eq && !r_res.match_found) begin
                r_res.match_found <= 1'b1;
                r_res.match_idx   <= i_idx;
                r_res.match_ent   <= i_ent;
            end
            if (better) begin
                r_res.victim_found <= 1'b1;
                r_res.victim_idx   <= i_idx;
                r_res.victim_ent   <= i_ent;
            end
            if (drop) begin
                r_res.drop_mask[i_idx]     <= 1'b1;
                r_res.drop_rank[i_ent.order] <= 1'b1;
            end
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

/* rtl/keyed_lru_entry_cache.sv */
// Fully associative cache of eight keyed entries with least-recently-touched
// replacement; one operation per input word gives one result word. Every
// operation reads all entries from the entry RAM one per cycle. A lookup, a
// peek, a matched update or record, a miss that inserts nothing and a removal
// that removes nothing go through the scan, a decide state and a done state. A
// plain insert adds a write state. A removal that drops entries adds a pass over
// all entries that renumbers the insertion ranks, and an insert that evicts takes
// the pass and the write state. The next word is taken at the earliest in the
// cycle after the result is loaded; a stalled result that still holds the output
// register keeps the block in its done state and so holds the next word back.
// A new word is taken while the previous result still waits.
// Depends on kle_pkg, kle_ram and kle_scan.
`default_nettype none
module keyed_lru_entry_cache (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [kle_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [63:0] i_resource_handle,
    input  wire logic [15:0] i_surface_width,
    input  wire logic [15:0] i_surface_height,
    input  wire logic [31:0] i_pixel_format,
    input  wire logic [31:0] i_resource_generation,
    input  wire logic [31:0] i_resize_generation,
    input  wire logic [31:0] i_frame_now,
    input  wire logic [31:0] i_age_limit,
    input  wire logic [2:0]  i_flags_in,
    input  wire logic [31:0] i_hits_in,
    input  wire logic [31:0] i_first_frame_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [2:0]       o_flags_out,
    output logic [31:0]      o_hits_out,
    output logic [31:0]      o_first_frame_out,
    output logic [31:0]      o_last_touch_out,
    output logic [3:0]       o_removed_count,
    output logic [3:0]       o_live_count
);
    import kle_pkg::*;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [3:0]         r_limit;
    logic [SLOTS-1:0]   r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_idx;
    logic               r_rd_v;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [SLOTS-1:0]   r_drop_rank;
    logic               r_insert;
    t_result            r_res;
    t_result            r_out;
    logic               r_out_valid;

    logic               accept;
    logic               out_free;
    logic               scan_clear;
    logic               last_idx;
    t_scan_res          scan;
    t_entry             rdata;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    t_entry             wdata;
    t_entry             upd;
    t_entry             fresh;
    logic [CNT_W-1:0]   lim;
    logic               is_insert_mode;
    logic               is_remove_mode;
    logic               evict;
    logic [CNT_W-1:0]   drop_cnt;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   rank_dec;
    logic [SLOTS-1:0]   valid_after;
    t_result            dec_res;
    logic [SLOTS-1:0]   dec_drop_rank;

    assign pready   = 1'b1;
    assign prdata   = {28'd0, r_limit};
    assign accept   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign last_idx = (r_idx == CNT_W'(SLOTS));

    kle_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    kle_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (scan_clear),
        .i_sample     (r_rd_v && (r_state == ST_SCAN)),
        .i_idx        (r_rd_idx),
        .i_slot_valid (r_valid[r_rd_idx]),
        .i_ent        (rdata),
        .i_op         (r_op),
        .o_res        (scan)
    );

    // Decision logic for the word under work.
    always_comb begin
        if (r_limit < 4'(MIN_LIMIT)) begin
            lim = CNT_W'(MIN_LIMIT);
        end else if (r_limit > 4'(SLOTS)) begin
            lim = CNT_W'(SLOTS);
        end else begin
            lim = CNT_W'(r_limit);
        end
        is_insert_mode = (r_op.mode == MODE_ASSIGN) || (r_op.mode == MODE_REC_REJECTED) ||
                         (r_op.mode == MODE_REC_ACCEPTED);
        is_remove_mode = (r_op.mode == MODE_DROP_EPOCH) ||
                         (r_op.mode == MODE_DROP_RESOURCE) || (r_op.mode == MODE_RETIRE);
        evict = (r_count >= lim) && scan.victim_found;

        upd = scan.match_ent;
        case (r_op.mode)
            MODE_LOOKUP: begin
                upd.last = r_op.frame;
                if (scan.match_ent.hits != 32'hFFFF_FFFF) begin
                    upd.hits = scan.match_ent.hits + 32'd1;
                end
            end
            MODE_ASSIGN: begin
                upd.flags = r_op.flags;
                upd.hits  = r_op.hits;
                upd.first = r_op.first;
                upd.last  = r_op.frame;
            end
            MODE_REC_REJECTED: upd.flags = scan.match_ent.flags | FLAG_REJECTED;
            MODE_REC_ACCEPTED: upd.flags = scan.match_ent.flags | FLAG_ACCEPTED;
            default: ;
        endcase

        fresh.handle = r_op.handle;
        fresh.size   = r_op.size;
        fresh.fmt    = r_op.fmt;
        fresh.epochs = r_op.epochs;
        fresh.order  = r_count[IDX_W-1:0];
        if (r_op.mode == MODE_ASSIGN) begin
            fresh.flags = r_op.flags;
            fresh.hits  = r_op.hits;
            fresh.first = r_op.frame;
            fresh.last  = r_op.frame;
        end else begin
            fresh.flags = (r_op.mode == MODE_REC_REJECTED) ? FLAG_REJECTED : FLAG_ACCEPTED;
            fresh.hits  = '0;
            fresh.first = '0;
            fresh.last  = '0;
        end

        drop_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            drop_cnt = drop_cnt + CNT_W'(scan.drop_mask[i]);
        end
        valid_after = r_valid & ~scan.drop_mask;

        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end

        // A surviving entry moves down by the number of removed ranks below it.
        rank_dec = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_drop_rank[i] && (IDX_W'(i) < rdata.order)) begin
                rank_dec = rank_dec + IDX_W'(1);
            end
        end

        dec_res       = '0;
        dec_res.live  = r_count;
        dec_drop_rank = '0;
        if (is_remove_mode) begin
            dec_res.removed = drop_cnt;
            dec_res.live    = r_count - drop_cnt;
            dec_drop_rank   = scan.drop_rank;
        end else if (scan.match_found) begin
            dec_res.hit   = 1'b1;
            dec_res.flags = upd.flags;
            dec_res.hits  = upd.hits;
            dec_res.first = upd.first;
            dec_res.last  = upd.last;
        end else if (is_insert_mode && evict) begin
            dec_res.removed = CNT_W'(1);
            dec_drop_rank[scan.victim_ent.order] = 1'b1;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (accept) n_state = ST_SCAN;
            ST_SCAN:   if (last_idx) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (is_remove_mode) begin
                    n_state = (drop_cnt != '0) ? ST_RENUM : ST_DONE;
                end else if (scan.match_found || !is_insert_mode) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = evict ? ST_RENUM : ST_WRITE;
                end
            end
            ST_RENUM:  if (last_idx) n_state = r_insert ? ST_WRITE : ST_DONE;
            ST_WRITE:  n_state = ST_DONE;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_stall    = 1'b1;
        scan_clear = 1'b0;
        we         = 1'b0;
        waddr      = scan.match_idx;
        wdata      = upd;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                scan_clear = 1'b1;
            end
            ST_DECIDE: begin
                we = scan.match_found && (r_op.mode != MODE_PEEK) && !is_remove_mode;
            end
            ST_RENUM: begin
                we    = r_rd_v && r_valid[r_rd_idx];
                waddr = r_rd_idx;
                wdata = rdata;
                wdata.order = rdata.order - rank_dec;
            end
            ST_WRITE: begin
                we    = 1'b1;
                waddr = free_idx;
                wdata = fresh;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= 4'(SLOTS);
            r_valid     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_insert    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite) begin
                r_limit <= pwdata[3:0];
            end
            r_rd_v   <= ((r_state == ST_SCAN) || (r_state == ST_RENUM)) && !last_idx;
            r_rd_idx <= r_idx[IDX_W-1:0];
            if ((r_state == ST_SCAN || r_state == ST_RENUM) && !last_idx) begin
                r_idx <= r_idx + CNT_W'(1);
            end else begin
                r_idx <= '0;
            end

            if (accept) begin
                r_op.mode   <= t_mode'(i_mode);
                r_op.handle <= i_resource_handle;
                r_op.size   <= {i_surface_height, i_surface_width};
                r_op.fmt    <= i_pixel_format;
                r_op.epochs <= {i_resize_generation, i_resource_generation};
                r_op.frame  <= i_frame_now;
                r_op.age    <= i_age_limit;
                r_op.flags  <= i_flags_in;
                r_op.hits   <= i_hits_in;
                r_op.first  <= i_first_frame_in;
            end

            if (r_state == ST_DECIDE) begin
                r_res       <= dec_res;
                r_drop_rank <= dec_drop_rank;
                r_insert    <= is_insert_mode && !scan.match_found;
                if (is_remove_mode) begin
                    r_valid <= valid_after;
                    r_count <= r_count - drop_cnt;
                end else if (is_insert_mode && !scan.match_found && evict) begin
                    r_valid[scan.victim_idx] <= 1'b0;
                    r_count                  <= r_count - CNT_W'(1);
                end
            end

            if (r_state == ST_WRITE) begin
                r_valid[free_idx] <= 1'b1;
                r_count           <= r_count + CNT_W'(1);
                r_res.flags       <= fresh.flags;
                r_res.hits        <= fresh.hits;
                r_res.first       <= fresh.first;
                r_res.last        <= fresh.last;
                r_res.live        <= r_count + CNT_W'(1);
            end

            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_hit             = r_out.hit;
    assign o_flags_out       = r_out.flags;
    assign o_hits_out        = r_out.hits;
    assign o_first_frame_out = r_out.first;
    assign o_last_touch_out  = r_out.last;
    assign o_removed_count   = r_out.removed;
    assign o_live_count      = r_out.live;

endmodule
`default_nettype wire
